@@ design/snr_pkg.sv @@
// Shared types and constants for the subgraph node relabeler.
package snr_pkg;

    // Item operation codes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_SEED  = 2'd1;
    localparam logic [1:0] OP_EDGE  = 2'd2;

    // Multiplicative hash constant (golden-ratio based)
    localparam logic [31:0] HASH_MULT = 32'd2654435761;

    // Top-level sequencer states
    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_DISPATCH,
        TOP_LOOKUP,
        TOP_FINISH
    } top_state_t;

    // Slot table sequencer states
    typedef enum logic [2:0] {
        TBL_SWEEP,
        TBL_IDLE,
        TBL_HASH,
        TBL_READ,
        TBL_CHECK
    } tbl_state_t;

    // Requests from the top sequencer to the slot table
    typedef struct packed {
        logic lookup;
        logic insert;
        logic clear;
    } tbl_req_t;

    // Status from the slot table back to the top sequencer
    typedef struct packed {
        logic busy;
        logic done;
        logic found;
        logic full;
    } tbl_rsp_t;

endpackage

@@ design/snr_slot_table.sv @@
// Hashed slot table with linear probing, clearing sweep and single-slot insert.
module snr_slot_table #(
    parameter int HASH_SLOTS = 8192,
    parameter int LABEL_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  snr_pkg::tbl_req_t     req,
    input  logic [31:0]           key,
    input  logic [LABEL_BITS-1:0] ins_label,
    output snr_pkg::tbl_rsp_t     rsp,
    output logic [LABEL_BITS-1:0] hit_label
);

    localparam int HB = $clog2(HASH_SLOTS);
    localparam int W  = 1 + 32 + LABEL_BITS;
    localparam logic [HB-1:0] LAST_SLOT = HB'(HASH_SLOTS - 1);

    // Slot word: {used, key, label}
    logic [W-1:0] mem [HASH_SLOTS];

    snr_pkg::tbl_state_t state_reg, state_next;
    logic [31:0]   key_reg, key_next;
    logic [HB-1:0] addr_reg, addr_next;
    logic [HB-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  rd_reg;

    logic          wr_en;
    logic [W-1:0]  wr_data;
    logic [HB-1:0] hash_val;
    logic          rd_used;
    logic          rd_match;

    // Low bits of the product only depend on low bits of the operands
    assign hash_val = HB'(key_reg[HB-1:0] * snr_pkg::HASH_MULT[HB-1:0]);
    assign rd_used  = rd_reg[W-1];
    assign rd_match = (rd_reg[W-2 -: 32] == key_reg);
    assign hit_label = rd_reg[LABEL_BITS-1:0];

    // Memory: one write, one registered read at the probe address
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr_reg] <= wr_data;
        end
        rd_reg <= mem[addr_reg];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            snr_pkg::TBL_SWEEP:
            begin
                if (addr_reg == LAST_SLOT)
                begin
                    state_next = snr_pkg::TBL_IDLE;
                end
            end
            snr_pkg::TBL_IDLE:
            begin
                if (req.clear)
                begin
                    state_next = snr_pkg::TBL_SWEEP;
                end
                else if (req.lookup)
                begin
                    state_next = snr_pkg::TBL_HASH;
                end
            end
            snr_pkg::TBL_HASH:
            begin
                state_next = snr_pkg::TBL_READ;
            end
            snr_pkg::TBL_READ:
            begin
                state_next = snr_pkg::TBL_CHECK;
            end
            snr_pkg::TBL_CHECK:
            begin
                if (!rd_used || rd_match || cnt_reg == LAST_SLOT)
                begin
                    state_next = snr_pkg::TBL_IDLE;
                end
                else
                begin
                    state_next = snr_pkg::TBL_READ;
                end
            end
            default:
            begin
                state_next = snr_pkg::TBL_IDLE;
            end
        endcase
    end

    // Outputs and datapath next values
    always_comb
    begin
        key_next  = key_reg;
        addr_next = addr_reg;
        cnt_next  = cnt_reg;
        wr_en     = 1'b0;
        wr_data   = '0;
        rsp       = '0;
        case (state_reg)
            snr_pkg::TBL_SWEEP:
            begin
                rsp.busy  = 1'b1;
                wr_en     = 1'b1;
                addr_next = addr_reg + 1'b1;
            end
            snr_pkg::TBL_IDLE:
            begin
                if (req.clear)
                begin
                    addr_next = '0;
                end
                else if (req.lookup)
                begin
                    key_next = key;
                end
            end
            snr_pkg::TBL_HASH:
            begin
                rsp.busy  = 1'b1;
                addr_next = hash_val;
                cnt_next  = '0;
            end
            snr_pkg::TBL_READ:
            begin
                rsp.busy = 1'b1;
            end
            snr_pkg::TBL_CHECK:
            begin
                rsp.busy = 1'b1;
                if (!rd_used || rd_match)
                begin
                    rsp.done  = 1'b1;
                    rsp.found = rd_used;
                    // addr_reg holds the hit or the first free slot of the chain
                    if (req.insert)
                    begin
                        wr_en   = 1'b1;
                        wr_data = {1'b1, key_reg, ins_label};
                    end
                end
                else if (cnt_reg == LAST_SLOT)
                begin
                    rsp.done = 1'b1;
                    rsp.full = 1'b1;
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                rsp.busy = 1'b1;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= snr_pkg::TBL_SWEEP;
            addr_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Payload register
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

endmodule

@@ design/subgraph_node_relabeler.sv @@
// Top level: relabels global node IDs into contiguous local labels.
//
// Input channel (in_valid/in_ready) takes one item: op, node_id,
// node_degree, edge_value. Op clear empties the map and zeroes all
// counters, op seed labels a seed node, op edge looks up or inserts a
// neighbour; op code 3 is dropped with no result. Every other item gives
// exactly one result on the output channel (out_valid/out_ready).
// A lookup item probes the slot table slot by slot along its collision
// chain (one slot memory read port). A refused seed on a full label
// space and a clear item skip the lookup. One item is in work at a
// time; in_ready is low until its result sits in the output register.
// Reset and every clear item start a sweep that zeroes the slot table;
// in_ready stays low until it ends.
// A stalled receiver holds the result in the output register; the next
// item may be accepted and worked on, but it waits for the register to
// free before it ends.
module subgraph_node_relabeler #(
    parameter int LABEL_CAPACITY = 4096,
    parameter int HASH_SLOTS     = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [31:0] node_id,
    input  logic [15:0] node_degree,
    input  logic [31:0] edge_value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] local_label,
    output logic        is_new_boundary,
    output logic [31:0] original_id,
    output logic [31:0] row_pointer,
    output logic [31:0] value_out,
    output logic [12:0] node_count,
    output logic        status
);

    localparam int LB = $clog2(LABEL_CAPACITY);
    localparam int CW = $clog2(LABEL_CAPACITY + 1);

    snr_pkg::top_state_t state_reg, state_next;

    // Captured item
    logic [1:0]  op_reg, op_next;
    logic [31:0] id_reg, id_next;
    logic [15:0] deg_reg, deg_next;
    logic [31:0] val_reg, val_next;

    // Counters
    logic [CW-1:0] seed_reg, seed_next;
    logic [CW-1:0] bnd_reg, bnd_next;
    logic [31:0]   run_reg, run_next;
    logic [31:0]   offs_reg, offs_next;

    // Result under construction
    logic [LB-1:0] res_label_reg, res_label_next;
    logic          res_fresh_reg, res_fresh_next;
    logic [31:0]   res_rowp_reg, res_rowp_next;
    logic          res_status_reg, res_status_next;

    // Output register
    logic          out_valid_reg, out_valid_next;
    logic [11:0]   out_label_reg, out_label_next;
    logic          out_fresh_reg, out_fresh_next;
    logic [31:0]   out_id_reg, out_id_next;
    logic [31:0]   out_rowp_reg, out_rowp_next;
    logic [31:0]   out_val_reg, out_val_next;
    logic [12:0]   out_count_reg, out_count_next;
    logic          out_status_reg, out_status_next;

    snr_pkg::tbl_req_t tbl_req;
    snr_pkg::tbl_rsp_t tbl_rsp;
    logic [LB-1:0] hit_label;
    logic [LB-1:0] ins_label;

    logic          in_acc;
    logic          out_free;
    logic [CW-1:0] sum;
    logic          cnt_full;
    logic          is_seed;
    logic          is_edge;
    logic          seed_store;
    logic          edge_store;
    logic          do_insert;

    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign sum      = seed_reg + bnd_reg;
    assign cnt_full = (sum >= CW'(LABEL_CAPACITY));
    assign is_seed  = (op_reg == snr_pkg::OP_SEED);
    assign is_edge  = (op_reg == snr_pkg::OP_EDGE);

    // Store decisions once the probe has ended
    assign seed_store = !cnt_full && (tbl_rsp.found || !tbl_rsp.full);
    assign edge_store = !tbl_rsp.found && !cnt_full && !tbl_rsp.full;
    assign do_insert  = (state_reg == snr_pkg::TOP_LOOKUP) && tbl_rsp.done &&
                        (is_seed ? seed_store : edge_store);
    assign ins_label  = is_seed ? LB'(seed_reg) : LB'(sum);

    snr_slot_table #(
        .HASH_SLOTS (HASH_SLOTS),
        .LABEL_BITS (LB)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (tbl_req),
        .key       (id_reg),
        .ins_label (ins_label),
        .rsp       (tbl_rsp),
        .hit_label (hit_label)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            snr_pkg::TOP_IDLE:
            begin
                if (in_acc && (op == snr_pkg::OP_CLEAR || op == snr_pkg::OP_SEED ||
                               op == snr_pkg::OP_EDGE))
                begin
                    state_next = snr_pkg::TOP_DISPATCH;
                end
            end
            snr_pkg::TOP_DISPATCH:
            begin
                if (op_reg == snr_pkg::OP_CLEAR || (is_seed && cnt_full))
                begin
                    state_next = snr_pkg::TOP_FINISH;
                end
                else
                begin
                    state_next = snr_pkg::TOP_LOOKUP;
                end
            end
            snr_pkg::TOP_LOOKUP:
            begin
                if (tbl_rsp.done)
                begin
                    state_next = snr_pkg::TOP_FINISH;
                end
            end
            snr_pkg::TOP_FINISH:
            begin
                if (out_free)
                begin
                    state_next = snr_pkg::TOP_IDLE;
                end
            end
            default:
            begin
                state_next = snr_pkg::TOP_IDLE;
            end
        endcase
    end

    // Handshake and table requests
    always_comb
    begin
        in_ready = 1'b0;
        tbl_req  = '0;
        case (state_reg)
            snr_pkg::TOP_IDLE:
            begin
                in_ready = !tbl_rsp.busy;
            end
            snr_pkg::TOP_DISPATCH:
            begin
                tbl_req.clear  = (op_reg == snr_pkg::OP_CLEAR);
                tbl_req.lookup = is_edge || (is_seed && !cnt_full);
            end
            snr_pkg::TOP_LOOKUP:
            begin
                tbl_req.insert = do_insert;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        op_next         = op_reg;
        id_next         = id_reg;
        deg_next        = deg_reg;
        val_next        = val_reg;
        seed_next       = seed_reg;
        bnd_next        = bnd_reg;
        run_next        = run_reg;
        offs_next       = offs_reg;
        res_label_next  = res_label_reg;
        res_fresh_next  = res_fresh_reg;
        res_rowp_next   = res_rowp_reg;
        res_status_next = res_status_reg;
        out_label_next  = out_label_reg;
        out_fresh_next  = out_fresh_reg;
        out_id_next     = out_id_reg;
        out_rowp_next   = out_rowp_reg;
        out_val_next    = out_val_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (in_acc)
        begin
            op_next  = op;
            id_next  = node_id;
            deg_next = node_degree;
            val_next = edge_value;
        end

        case (state_reg)
            snr_pkg::TOP_DISPATCH:
            begin
                res_label_next  = '0;
                res_fresh_next  = 1'b0;
                res_rowp_next   = '0;
                res_status_next = 1'b0;
                if (op_reg == snr_pkg::OP_CLEAR)
                begin
                    seed_next = '0;
                    bnd_next  = '0;
                    run_next  = '0;
                    offs_next = '0;
                end
                else if (is_seed && cnt_full)
                begin
                    res_status_next = 1'b1;
                    res_rowp_next   = run_reg;
                end
            end
            snr_pkg::TOP_LOOKUP:
            begin
                if (tbl_rsp.done)
                begin
                    if (is_seed)
                    begin
                        if (seed_store)
                        begin
                            res_label_next = ins_label;
                            seed_next      = seed_reg + 1'b1;
                            run_next       = run_reg + 32'(deg_reg);
                            res_rowp_next  = run_reg + 32'(deg_reg);
                        end
                        else
                        begin
                            res_status_next = 1'b1;
                            res_rowp_next   = run_reg;
                        end
                    end
                    else
                    begin
                        res_rowp_next = offs_reg;
                        offs_next     = offs_reg + 1'b1;
                        if (tbl_rsp.found)
                        begin
                            res_label_next = hit_label;
                        end
                        else if (edge_store)
                        begin
                            res_label_next = ins_label;
                            res_fresh_next = 1'b1;
                            bnd_next       = bnd_reg + 1'b1;
                        end
                        else
                        begin
                            res_status_next = 1'b1;
                        end
                    end
                end
            end
            snr_pkg::TOP_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_label_next  = 12'(res_label_reg);
                    out_fresh_next  = res_fresh_reg;
                    out_id_next     = (op_reg == snr_pkg::OP_CLEAR) ? 32'd0 : id_reg;
                    out_rowp_next   = res_rowp_reg;
                    out_val_next    = is_edge ? val_reg : 32'd0;
                    out_count_next  = 13'(sum);
                    out_status_next = res_status_reg;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !out_ready;
            end
        endcase
    end

    // Control state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= snr_pkg::TOP_IDLE;
            out_valid_reg <= 1'b0;
            seed_reg      <= '0;
            bnd_reg       <= '0;
            run_reg       <= '0;
            offs_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            seed_reg      <= seed_next;
            bnd_reg       <= bnd_next;
            run_reg       <= run_next;
            offs_reg      <= offs_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        deg_reg        <= deg_next;
        val_reg        <= val_next;
        res_label_reg  <= res_label_next;
        res_fresh_reg  <= res_fresh_next;
        res_rowp_reg   <= res_rowp_next;
        res_status_reg <= res_status_next;
        out_label_reg  <= out_label_next;
        out_fresh_reg  <= out_fresh_next;
        out_id_reg     <= out_id_next;
        out_rowp_reg   <= out_rowp_next;
        out_val_reg    <= out_val_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

    assign out_valid       = out_valid_reg;
    assign local_label     = out_label_reg;
    assign is_new_boundary = out_fresh_reg;
    assign original_id     = out_id_reg;
    assign row_pointer     = out_rowp_reg;
    assign value_out       = out_val_reg;
    assign node_count      = out_count_reg;
    assign status          = out_status_reg;

    // Labels handed out never exceed the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(seed_reg) + 32'(bnd_reg)) <= 32'(LABEL_CAPACITY))
        else $error("label count above capacity");

    // The table only reports a finished probe while a lookup is pending
    a_done_in_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_rsp.done |-> state_reg == snr_pkg::TOP_LOOKUP)
        else $error("probe result outside lookup");

    // A known neighbour is never inserted again
    a_no_dup_insert: assert property (@(posedge clk) disable iff (!rst_n)
        (is_edge && tbl_rsp.done && tbl_rsp.found) |-> !tbl_req.insert)
        else $error("insert of a neighbour already in the map");

    // A boundary insert advances the boundary count by one
    a_bnd_step: assert property (@(posedge clk) disable iff (!rst_n)
        (tbl_req.insert && is_edge) |=> bnd_reg == $past(bnd_reg) + 1'b1)
        else $error("boundary count did not advance on insert");

endmodule

@@ tb/sv/subgraph_node_relabeler_tb.sv @@
// Self-checking testbench for the subgraph node relabeler: directed table, then random subgraphs.
module subgraph_node_relabeler_tb;

    localparam int CLK_PERIOD   = 8;
    localparam int LABEL_CAP    = 4096;
    localparam int SLOTS        = 8192;
    localparam int RAND_ITEMS   = 1800;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 64;
    // ~1.9k items with long gaps, long stalls and probe chains, plus ~20 table sweeps,
    // stay under this limit in the worst case
    localparam int LIMIT_CYCLES = 4_000_000;

    // op code the block drops without a result
    localparam logic [1:0] OP_NONE = 2'd3;
    localparam logic STAT_OK   = 1'b0;
    localparam logic STAT_FULL = 1'b1;
    // low id bits that all land on one hash slot
    localparam logic [12:0] CLASH_LOW = 13'h0abc;

    typedef struct packed {
        logic [11:0] label;
        logic        fresh;
        logic [31:0] orig;
        logic [31:0] rowp;
        logic [31:0] vout;
        logic [12:0] count;
        logic        stat;
    } relabel_t;

    typedef struct packed {
        logic [1:0]  code;
        logic [31:0] id;
        logic [15:0] deg;
        logic [31:0] val;
        logic        typed;
        relabel_t    want;
    } dir_row_t;

    localparam int N_DIRECTED = 23;
    localparam dir_row_t DIRECTED [0:N_DIRECTED-1] = '{
        // edge straight after reset: first boundary node
        '{snr_pkg::OP_EDGE, 32'h0000_0007, 16'h0000, 32'h0000_0001, 1'b1,
          '{12'd0, 1'b1, 32'h0000_0007, 32'h0, 32'h0000_0001, 13'd1, STAT_OK}},
        '{snr_pkg::OP_CLEAR, 32'hffff_ffff, 16'hffff, 32'hffff_ffff, 1'b1, '0},
        '{snr_pkg::OP_SEED, 32'h0000_0000, 16'h0000, 32'hffff_ffff, 1'b1,
          '{12'd0, 1'b0, 32'h0, 32'h0, 32'h0, 13'd1, STAT_OK}},
        '{snr_pkg::OP_SEED, 32'hffff_ffff, 16'hffff, 32'h0000_0000, 1'b1,
          '{12'd1, 1'b0, 32'hffff_ffff, 32'h0000_ffff, 32'h0, 13'd2, STAT_OK}},
        '{snr_pkg::OP_EDGE, 32'h0000_0000, 16'hffff, 32'hffff_ffff, 1'b1,
          '{12'd0, 1'b0, 32'h0, 32'h0, 32'hffff_ffff, 13'd2, STAT_OK}},
        '{snr_pkg::OP_EDGE, 32'hffff_ffff, 16'h0000, 32'h0000_0000, 1'b1,
          '{12'd1, 1'b0, 32'hffff_ffff, 32'h1, 32'h0, 13'd2, STAT_OK}},
        '{snr_pkg::OP_EDGE, 32'h1234_5678, 16'h0000, 32'ha5a5_a5a5, 1'b1,
          '{12'd2, 1'b1, 32'h1234_5678, 32'h2, 32'ha5a5_a5a5, 13'd3, STAT_OK}},
        '{snr_pkg::OP_EDGE, 32'h1234_5678, 16'h0000, 32'h5a5a_5a5a, 1'b1,
          '{12'd2, 1'b0, 32'h1234_5678, 32'h3, 32'h5a5a_5a5a, 13'd3, STAT_OK}},
        '{OP_NONE, 32'hffff_ffff, 16'hffff, 32'hffff_ffff, 1'b0, '0},
        // duplicate seed, then a seed over a boundary entry
        '{snr_pkg::OP_SEED, 32'h0000_0000, 16'h0001, 32'h0, 1'b0, '0},
        '{snr_pkg::OP_SEED, 32'h1234_5678, 16'h0002, 32'h0, 1'b0, '0},
        '{snr_pkg::OP_EDGE, 32'h0000_0000, 16'h0000, 32'h0bad_f00d, 1'b0, '0},
        '{snr_pkg::OP_EDGE, 32'h1234_5678, 16'h0000, 32'h0000_00ff, 1'b0, '0},
        // ids sharing low bits with id 0 build a probe chain on one slot
        '{snr_pkg::OP_EDGE, 32'h0000_2000, 16'h0000, 32'h1111_1111, 1'b0, '0},
        '{snr_pkg::OP_EDGE, 32'h0000_4000, 16'h0000, 32'h2222_2222, 1'b0, '0},
        '{snr_pkg::OP_EDGE, 32'h0000_6000, 16'h0000, 32'h3333_3333, 1'b0, '0},
        '{snr_pkg::OP_EDGE, 32'h0000_4000, 16'h0000, 32'h4444_4444, 1'b0, '0},
        '{snr_pkg::OP_SEED, 32'h0000_6000, 16'h0003, 32'h0, 1'b0, '0},
        '{OP_NONE, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b0, '0},
        '{snr_pkg::OP_CLEAR, 32'h0000_0000, 16'h0000, 32'h0000_0000, 1'b1, '0},
        '{snr_pkg::OP_EDGE, 32'h8000_0000, 16'h0000, 32'h7fff_ffff, 1'b1,
          '{12'd0, 1'b1, 32'h8000_0000, 32'h0, 32'h7fff_ffff, 13'd1, STAT_OK}},
        '{snr_pkg::OP_SEED, 32'h8000_0000, 16'h8000, 32'h0, 1'b0, '0},
        '{snr_pkg::OP_EDGE, 32'h8000_0000, 16'h0000, 32'h0000_0000, 1'b0, '0}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic [31:0] node_id;
    logic [15:0] node_degree;
    logic [31:0] edge_value;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [11:0] local_label;
    logic        is_new_boundary;
    logic [31:0] original_id;
    logic [31:0] row_pointer;
    logic [31:0] value_out;
    logic [12:0] node_count;
    logic        status;

    // predicted relabel map and counters
    logic        map_used  [SLOTS];
    logic [31:0] map_key   [SLOTS];
    logic [11:0] map_label [SLOTS];
    int unsigned seeds_n;
    int unsigned bounds_n;
    logic [31:0] edge_sum;
    logic [31:0] edge_idx;

    relabel_t    relabel_q[$];
    relabel_t    last_pred;
    logic [31:0] seed_pool[$];
    logic [31:0] bound_pool[$];

    int  err_count;
    int  checked_n;
    int  cycle_no;
    int  n_clear, n_seed, n_edge, n_ignored, n_boundary, n_refused;
    bit  tx_calm;
    bit  rx_calm;
    int  rx_hold;

    subgraph_node_relabeler #(
        .LABEL_CAPACITY (LABEL_CAP),
        .HASH_SLOTS     (SLOTS)
    ) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .node_id         (node_id),
        .node_degree     (node_degree),
        .edge_value      (edge_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .local_label     (local_label),
        .is_new_boundary (is_new_boundary),
        .original_id     (original_id),
        .row_pointer     (row_pointer),
        .value_out       (value_out),
        .node_count      (node_count),
        .status          (status)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // empty map, zero all counters
    function automatic void clear_map();
        foreach (map_used[i])
            map_used[i] = 1'b0;
        seeds_n  = 0;
        bounds_n = 0;
        edge_sum = '0;
        edge_idx = '0;
    endfunction

    // linear probe: hit with its slot, or the first free slot (SLOTS when none)
    function automatic bit map_probe(input logic [31:0] key, output int slot);
        logic [31:0] prod;
        int          h;
        prod = key * snr_pkg::HASH_MULT;
        h = int'(prod % SLOTS);
        for (int n = 0; n < SLOTS; n++)
        begin
            if (!map_used[h])
            begin
                slot = h;
                return 1'b0;
            end
            if (map_key[h] == key)
            begin
                slot = h;
                return 1'b1;
            end
            h = (h + 1) % SLOTS;
        end
        slot = SLOTS;
        return 1'b0;
    endfunction

    // one item through the relabeler; returns 0 when no result comes out
    function automatic bit relabel_node(input logic [1:0] code, input logic [31:0] id,
                                        input logic [15:0] deg, input logic [31:0] val,
                                        output relabel_t res);
        int slot;
        bit hit;
        res = '0;
        if (code == OP_NONE)
            return 1'b0;
        if (code == snr_pkg::OP_CLEAR)
        begin
            clear_map();
        end
        else if (code == snr_pkg::OP_SEED)
        begin
            res.orig = id;
            hit = map_probe(id, slot);
            if (seeds_n + bounds_n >= LABEL_CAP || (!hit && slot >= SLOTS))
            begin
                res.stat = STAT_FULL;
            end
            else
            begin
                res.label       = 12'(seeds_n);
                map_used[slot]  = 1'b1;
                map_key[slot]   = id;
                map_label[slot] = 12'(seeds_n);
                seeds_n++;
                edge_sum += 32'(deg);
            end
            res.rowp = edge_sum;
        end
        else
        begin
            res.orig = id;
            res.rowp = edge_idx;
            res.vout = val;
            edge_idx++;
            hit = map_probe(id, slot);
            if (hit)
            begin
                res.label = map_label[slot];
            end
            else if (seeds_n + bounds_n >= LABEL_CAP || slot >= SLOTS)
            begin
                res.stat = STAT_FULL;
            end
            else
            begin
                res.label       = 12'(seeds_n + bounds_n);
                map_used[slot]  = 1'b1;
                map_key[slot]   = id;
                map_label[slot] = 12'(seeds_n + bounds_n);
                bounds_n++;
                res.fresh = 1'b1;
            end
        end
        res.count = 13'(seeds_n + bounds_n);
        return 1'b1;
    endfunction

    function automatic string fmt_result(input relabel_t r);
        return $sformatf("label=%0d new=%0b id=%h row=%h value=%h count=%0d status=%0b",
                         r.label, r.fresh, r.orig, r.rowp, r.vout, r.count, r.stat);
    endfunction

    // names of the fields that disagree, empty on a match
    function automatic string result_diff(input relabel_t got, input relabel_t want);
        string s;
        s = "";
        if (got.label !== want.label) s = {s, " local_label"};
        if (got.fresh !== want.fresh) s = {s, " is_new_boundary"};
        if (got.orig  !== want.orig)  s = {s, " original_id"};
        if (got.rowp  !== want.rowp)  s = {s, " row_pointer"};
        if (got.vout  !== want.vout)  s = {s, " value_out"};
        if (got.count !== want.count) s = {s, " node_count"};
        if (got.stat  !== want.stat)  s = {s, " status"};
        return s;
    endfunction

    task automatic log_mismatch(input string why, input relabel_t got, input relabel_t want);
        err_count++;
        if (err_count <= MAX_REPORTS)
        begin
            $display("ERROR result %0d: %s", checked_n, why);
            $display("  expected %s", fmt_result(want));
            $display("  actual   %s", fmt_result(got));
        end
    endtask

    // sender gap: mostly none, some short, a few long
    function automatic int send_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // random node id: plain, extreme, or on the shared hash slot
    function automatic logic [31:0] fresh_node();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 32'h0000_0000;
        if (r == 1)
            return 32'hffff_ffff;
        if (r < 4)
            return {19'($urandom), CLASH_LOW};
        return $urandom;
    endfunction

    // present one item, hold it until accepted, then queue its prediction
    task automatic offer_item(input logic [1:0] code, input logic [31:0] id,
                              input logic [15:0] deg, input logic [31:0] val,
                              input bit typed, input relabel_t want);
        int       gap;
        relabel_t pred;
        bit       has;
        gap = send_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= code;
        node_id     <= id;
        node_degree <= deg;
        edge_value  <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        has = relabel_node(code, id, deg, val, pred);
        last_pred = pred;
        if (has)
            relabel_q.insert(relabel_q.size(), typed ? want : pred);
        case (code)
            snr_pkg::OP_CLEAR: n_clear++;
            snr_pkg::OP_SEED:  n_seed++;
            snr_pkg::OP_EDGE:  n_edge++;
            default:           n_ignored++;
        endcase
        if (pred.fresh)
            n_boundary++;
        if (pred.stat == STAT_FULL)
            n_refused++;
    endtask

    // result check and receiver stalls
    always @(posedge clk)
    begin
        relabel_t got;
        relabel_t want;
        int       r;
        string    diff;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{local_label, is_new_boundary, original_id, row_pointer, value_out,
                    node_count, status};
            checked_n++;
            if (relabel_q.size() == 0)
            begin
                log_mismatch("result with nothing pending", got, '0);
            end
            else
            begin
                want = relabel_q.pop_front();
                diff = result_diff(got, want);
                if (diff != "")
                    log_mismatch({"wrong", diff}, got, want);
            end
        end
        if ($urandom_range(0, 399) == 0)
            rx_calm = !rx_calm;
        if (rx_hold > 0)
        begin
            rx_hold--;
            out_ready <= 1'b0;
        end
        else if (rx_calm)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                rx_hold = (r < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39);
                out_ready <= 1'b0;
            end
        end
    end

    // run timeout
    always @(posedge clk)
    begin
        cycle_no++;
        if (cycle_no == LIMIT_CYCLES)
        begin
            $display("timed out after %0d cycles, %0d results pending",
                     cycle_no, relabel_q.size());
            $display("subgraph_node_relabeler: mismatch");
            $finish;
        end
    end

    initial
    begin
        int          rand_items;
        int          n_seeds;
        int          n_edges;
        int          r;
        logic [31:0] id;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        op          = snr_pkg::OP_CLEAR;
        node_id     = '0;
        node_degree = '0;
        edge_value  = '0;
        rx_calm     = 1'b0;
        tx_calm     = 1'b0;
        clear_map();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int i = 0; i < N_DIRECTED; i++)
            offer_item(DIRECTED[i].code, DIRECTED[i].id, DIRECTED[i].deg,
                       DIRECTED[i].val, DIRECTED[i].typed, DIRECTED[i].want);

        // random subgraph extractions
        rand_items = 0;
        while (rand_items < RAND_ITEMS)
        begin
            tx_calm = ($urandom_range(0, 3) == 0);
            // usually a fresh subgraph; sometimes keep building on the old map
            if ($urandom_range(0, 4) != 0)
            begin
                offer_item(snr_pkg::OP_CLEAR, $urandom, 16'($urandom), $urandom, 1'b0, '0);
                seed_pool.delete();
                bound_pool.delete();
                rand_items++;
            end
            n_seeds = $urandom_range(1, 40);
            repeat (n_seeds)
            begin
                id = fresh_node();
                offer_item(snr_pkg::OP_SEED, id, 16'($urandom), $urandom, 1'b0, '0);
                seed_pool.insert(seed_pool.size(), id);
                rand_items++;
            end
            n_edges = $urandom_range(1, 150);
            repeat (n_edges)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                begin
                    offer_item(OP_NONE, $urandom, 16'($urandom), $urandom, 1'b0, '0);
                    rand_items++;
                end
                else if (r < 6)
                begin
                    // reseed a node already in the map
                    if (bound_pool.size() > 0 && r == 5)
                        id = bound_pool[$urandom_range(0, bound_pool.size() - 1)];
                    else
                        id = seed_pool[$urandom_range(0, seed_pool.size() - 1)];
                    offer_item(snr_pkg::OP_SEED, id, 16'($urandom), $urandom, 1'b0, '0);
                    rand_items++;
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < 35)
                        id = seed_pool[$urandom_range(0, seed_pool.size() - 1)];
                    else if (r < 60 && bound_pool.size() > 0)
                        id = bound_pool[$urandom_range(0, bound_pool.size() - 1)];
                    else if (r < 90)
                        id = fresh_node();
                    else
                        id = {19'($urandom), CLASH_LOW};
                    offer_item(snr_pkg::OP_EDGE, id, 16'($urandom), $urandom, 1'b0, '0);
                    if (last_pred.fresh)
                        bound_pool.insert(bound_pool.size(), id);
                    rand_items++;
                end
            end
        end
        in_valid <= 1'b0;

        // drain
        while (relabel_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d clears, %0d seeds, %0d edges, %0d dropped op codes",
                 n_clear, n_seed, n_edge, n_ignored);
        $display("%0d boundary inserts, %0d refusals on a full label space, %0d results checked",
                 n_boundary, n_refused, checked_n);
        if (err_count == 0 && relabel_q.size() == 0)
        begin
            $display("subgraph_node_relabeler: match");
        end
        else
        begin
            $display("%0d mismatches, %0d results never arrived", err_count, relabel_q.size());
            $display("subgraph_node_relabeler: mismatch");
        end
        $finish;
    end

endmodule

@@ subgraph_node_relabeler.f @@
design/snr_pkg.sv
design/snr_slot_table.sv
design/subgraph_node_relabeler.sv
tb/sv/subgraph_node_relabeler_tb.sv
